FILE: rtl/core/u16u8_pkg.sv
// Package for the UTF-16 to UTF-8 transcoder: payload structs, code constants
// and the UTF-8 byte encoder. It depends on nothing else.
`default_nettype none

package u16u8_pkg;

  localparam int unsigned MAX_CAPACITY_DEF = 65536;
  localparam logic [16:0] CAPACITY_RESET   = 17'h10000;

  localparam logic [15:0] SURR_HIGH_MIN = 16'hd800;
  localparam logic [15:0] SURR_HIGH_MAX = 16'hdbff;
  localparam logic [15:0] SURR_LOW_MIN  = 16'hdc00;
  localparam logic [15:0] SURR_LOW_MAX  = 16'hdfff;
  localparam logic [20:0] REPLACEMENT   = 21'h00fffd;

  localparam logic [7:0]  LEAD_TWO      = 8'hc0;
  localparam logic [7:0]  CONT_MARK     = 8'h80;

  localparam logic CMD_UNIT = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam int unsigned MAX_RESULTS = 6;

  typedef struct packed {
    logic        cmd;
    logic [15:0] code_unit;
  } src_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        is_status;
    logic [15:0] bytes_written;
    logic        input_valid;
    logic        truncated;
    logic        last;
  } res_t;

  // One encoded character: its length and bytes in emission order.
  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] bytes;
  } enc_t;

  function automatic enc_t utf8_encode(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.len      = 3'd1;
      e.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      e.len      = 3'd2;
      e.bytes[0] = LEAD_TWO | {3'b000, cp[10:6]};
      e.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
    end else if (cp < 21'h10000) begin
      e.len      = 3'd3;
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
      e.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
    end else begin
      e.len      = 3'd4;
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
      e.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
      e.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
    end
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/utf16_to_utf8_bounded_transcoder.sv
// UTF-16 to UTF-8 transcoder with a bounded output buffer; uses u16u8_pkg.
// A request passes the input register, the result buffer and the output register.
// Throughput: one result per cycle while res_stall is low, set by the single
// output register that drains the result buffer.
// Reset (rst, synchronous): string state cleared, capacity back to 65536,
// both channels empty.
`default_nettype none

module utf16_to_utf8_bounded_transcoder
  #(parameter int unsigned MAX_CAPACITY = u16u8_pkg::MAX_CAPACITY_DEF)
  (input  wire logic              clk,
   input  wire logic              rst,
   input  wire logic              cfg_wen,
   input  wire logic [16:0]       cfg_wdata,
   input  wire logic              src_valid,
   output      logic              src_stall,
   input  wire u16u8_pkg::src_t   src_data,
   output      logic              res_valid,
   input  wire logic              res_stall,
   output      u16u8_pkg::res_t   res_data);

  import u16u8_pkg::*;

  localparam logic [31:0] MAX_CAP = 32'(MAX_CAPACITY);
  localparam int unsigned IDX_W   = $clog2(MAX_RESULTS);

  // Usable bytes (capacity minus terminator), clamped to the parameter and to
  // the 16-bit byte counter. Worked out once, when the register is written.
  function automatic logic [15:0] usable_of(input logic [16:0] cap);
    logic [31:0] lim;
    logic [31:0] dec;
    lim = (32'(cap) > MAX_CAP) ? MAX_CAP : 32'(cap);
    dec = lim - 32'd1;
    if (lim == 32'd0) begin
      return 16'd0;
    end else if (dec > 32'h0000ffff) begin
      return 16'hffff;
    end
    return dec[15:0];
  endfunction

  logic [15:0] usable;

  always_ff @(posedge clk) begin
    if (rst) begin
      usable <= usable_of(CAPACITY_RESET);
    end else if (cfg_wen) begin
      usable <= usable_of(cfg_wdata);
    end
  end

  // Input register. It releases its request into the result buffer once the
  // buffer is empty or is handing over its last entry in this cycle.
  logic in_vld;
  src_t in_q;
  logic take;
  logic out_load;
  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] idx;

  assign out_load  = !res_valid || !res_stall;
  assign take      = in_vld && ((cnt == '0) || ((cnt == IDX_W'(1)) && out_load));
  assign src_stall = in_vld && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!src_stall) begin
      in_vld <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!src_stall && src_valid) begin
      in_q <= src_data;
    end
  end

  // String state.
  logic [15:0] pending_high;
  logic        pending_flag;
  logic [15:0] byte_count;
  logic        valid_flag;
  logic        truncated_flag;

  logic [15:0] pending_high_next;
  logic        pending_flag_next;
  logic [15:0] byte_count_next;
  logic        valid_flag_next;
  logic        truncated_flag_next;

  res_t [MAX_RESULTS-1:0] slots;
  logic [IDX_W-1:0]       n_res;

  // One request yields at most two characters: a replacement for a pending
  // high surrogate that is not completed (char A), then the character that
  // the current unit stands for (char B). Each is written only if it fits
  // whole; the first that does not fit latches the truncated flag.
  always_comb begin
    logic [15:0] u;
    logic        is_high;
    logic        is_low;
    logic        is_end;
    logic        emit_a;
    logic        has_b;
    logic        lone_low;
    logic [20:0] cp_b;
    logic [20:0] pair_cp;
    enc_t        enc_a;
    enc_t        enc_b;
    logic [16:0] sum_a;
    logic [16:0] sum_b;
    logic        a_out;
    logic        b_out;
    logic        trunc1;
    logic [15:0] count1;
    logic [2:0]  n_a;
    logic [2:0]  n_b;
    logic [2:0]  j;

    u        = in_q.code_unit;
    is_end   = (in_q.cmd == CMD_END);
    is_high  = (u >= SURR_HIGH_MIN) && (u <= SURR_HIGH_MAX);
    is_low   = (u >= SURR_LOW_MIN) && (u <= SURR_LOW_MAX);
    pair_cp  = 21'h10000 + {1'b0, pending_high[9:0], u[9:0]};

    emit_a   = pending_flag && (is_end || !is_low);
    lone_low = !is_end && is_low && !pending_flag;
    has_b    = !is_end && !is_high;
    if (!is_end && pending_flag && is_low) begin
      cp_b = pair_cp;
    end else if (lone_low) begin
      cp_b = REPLACEMENT;
    end else begin
      cp_b = {5'd0, u};
    end

    enc_a = utf8_encode(REPLACEMENT);
    enc_b = utf8_encode(cp_b);

    sum_a  = {1'b0, byte_count} + 17'(enc_a.len);
    a_out  = emit_a && !truncated_flag && (sum_a <= {1'b0, usable});
    trunc1 = truncated_flag || (emit_a && !a_out);
    count1 = a_out ? sum_a[15:0] : byte_count;

    sum_b  = {1'b0, count1} + 17'(enc_b.len);
    b_out  = has_b && !trunc1 && (sum_b <= {1'b0, usable});
    truncated_flag_next = trunc1 || (has_b && !b_out);
    byte_count_next     = b_out ? sum_b[15:0] : count1;
    valid_flag_next     = valid_flag && !emit_a && !lone_low;

    n_a   = a_out ? enc_a.len : 3'd0;
    n_b   = b_out ? enc_b.len : 3'd0;
    n_res = IDX_W'(n_a + n_b + {2'b00, is_end});

    for (int k = 0; k < MAX_RESULTS; k++) begin
      slots[k] = '0;
      j = 3'(k) - n_a;
      if (3'(k) < n_a) begin
        slots[k].out_byte = enc_a.bytes[k[1:0]];
        slots[k].has_byte = 1'b1;
      end else if (3'(k) < (n_a + n_b)) begin
        slots[k].out_byte = enc_b.bytes[j[1:0]];
        slots[k].has_byte = 1'b1;
      end else if (is_end && (3'(k) == (n_a + n_b))) begin
        slots[k].is_status     = 1'b1;
        slots[k].bytes_written = byte_count_next;
        slots[k].input_valid   = valid_flag_next;
        slots[k].truncated     = truncated_flag_next;
      end
      slots[k].last = (n_res != '0) && (IDX_W'(k) == (n_res - IDX_W'(1)));
    end

    if (is_end) begin
      pending_flag_next = 1'b0;
      pending_high_next = 16'd0;
    end else if (pending_flag && is_low) begin
      pending_flag_next = 1'b0;
      pending_high_next = 16'd0;
    end else begin
      pending_flag_next = is_high;
      pending_high_next = is_high ? u : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_high   <= 16'd0;
      pending_flag   <= 1'b0;
      byte_count     <= 16'd0;
      valid_flag     <= 1'b1;
      truncated_flag <= 1'b0;
    end else if (take) begin
      pending_high <= pending_high_next;
      pending_flag <= pending_flag_next;
      if (in_q.cmd == CMD_END) begin
        // The status has already been formed from the updated values.
        byte_count     <= 16'd0;
        valid_flag     <= 1'b1;
        truncated_flag <= 1'b0;
      end else begin
        byte_count     <= byte_count_next;
        valid_flag     <= valid_flag_next;
        truncated_flag <= truncated_flag_next;
      end
    end
  end

  // Result buffer: the results of one request, drained one per cycle into
  // the output register while the output is not stalled. A new request may
  // load it in the same cycle that its last entry leaves.
  res_t [MAX_RESULTS-1:0] res_buf;
  logic                   pop;

  assign pop = (cnt != '0) && out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (take) begin
      cnt <= n_res;
      idx <= '0;
    end else if (pop) begin
      cnt <= cnt - IDX_W'(1);
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_buf <= slots;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= (cnt != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_data <= res_buf[idx];
    end
  end

  // The buffer never holds more than one request's worth of results.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= IDX_W'(MAX_RESULTS))
    else $error("result buffer count out of range");

  // Every result is either a byte or the status, never both.
  a_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.has_byte != res_data.is_status))
    else $error("result is neither a byte nor a status");

  // The status closes its request.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.is_status) |-> res_data.last)
    else $error("status result without last");

  // An end request leaves the string state as after reset.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (take && (in_q.cmd == CMD_END)) |=>
      (!pending_flag && (byte_count == 16'd0) && valid_flag && !truncated_flag))
    else $error("string state not cleared after end");

  // Written bytes never exceed the usable space.
  a_count_fits: assert property (@(posedge clk) disable iff (rst || cfg_wen)
    (take && (in_q.cmd == CMD_UNIT)) |-> (byte_count_next <= usable)
      || (byte_count_next == byte_count))
    else $error("byte count beyond usable space");

endmodule

`default_nettype wire
